[rtl/si_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package si_pkg;

    // result codes of one transaction
    typedef enum logic [1:0] {
        ST_MISS      = 2'd0,
        ST_HIT       = 2'd1,
        ST_COLLINEAR = 2'd2
    } t_status;

    localparam int unsigned STATUS_BITS = 2;

endpackage

`default_nettype wire

[rtl/si_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// segment pair channel
interface si_in_if #(
    parameter int unsigned W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] ax_start;
    logic signed [W-1:0] ay_start;
    logic signed [W-1:0] ax_end;
    logic signed [W-1:0] ay_end;
    logic signed [W-1:0] bx_start;
    logic signed [W-1:0] by_start;
    logic signed [W-1:0] bx_end;
    logic signed [W-1:0] by_end;

    modport source (
        output valid, ax_start, ay_start, ax_end, ay_end,
        output bx_start, by_start, bx_end, by_end,
        input  ready
    );
    modport sink (
        input  valid, ax_start, ay_start, ax_end, ay_end,
        input  bx_start, by_start, bx_end, by_end,
        output ready
    );
endinterface

// intersection result channel
interface si_out_if #(
    parameter int unsigned W = 16
);
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic signed [W-1:0] cross_x;
    logic signed [W-1:0] cross_y;

    modport source (output valid, status, cross_x, cross_y, input ready);
    modport sink   (input valid, status, cross_x, cross_y, output ready);
endinterface

`default_nettype wire

[rtl/si_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module si_front #(
    parameter int unsigned W = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_adv,
    input  wire logic                    i_valid,
    input  wire logic signed [W-1:0]     i_x1,
    input  wire logic signed [W-1:0]     i_y1,
    input  wire logic signed [W-1:0]     i_x2,
    input  wire logic signed [W-1:0]     i_y2,
    input  wire logic signed [W-1:0]     i_x3,
    input  wire logic signed [W-1:0]     i_y3,
    input  wire logic signed [W-1:0]     i_x4,
    input  wire logic signed [W-1:0]     i_y4,
    output logic                         o_valid,
    output si_pkg::t_status              o_status,
    output logic [2*W+2:0]               o_dm,
    output logic [2*W+2:0]               o_fm,
    output logic [W:0]                   o_amx,
    output logic [W:0]                   o_amy,
    output logic                         o_negx,
    output logic                         o_negy,
    output logic signed [W-1:0]          o_bx,
    output logic signed [W-1:0]          o_by
);
    import si_pkg::*;

    localparam int unsigned DW = W + 1;
    localparam int unsigned PW = 2 * W + 2;
    localparam int unsigned FW = PW + 1;

    // stage a: differences and box test
    logic                 r_va, n_box;
    logic                 r_boxa;
    logic signed [W-1:0]  r_x1a, r_y1a;
    logic signed [DW-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [W-1:0]  alo_x, ahi_x, blo_x, bhi_x, alo_y, ahi_y, blo_y, bhi_y;

    always_comb begin
        alo_x = (i_x1 < i_x2) ? i_x1 : i_x2;
        ahi_x = (i_x1 < i_x2) ? i_x2 : i_x1;
        blo_x = (i_x3 < i_x4) ? i_x3 : i_x4;
        bhi_x = (i_x3 < i_x4) ? i_x4 : i_x3;
        alo_y = (i_y1 < i_y2) ? i_y1 : i_y2;
        ahi_y = (i_y1 < i_y2) ? i_y2 : i_y1;
        blo_y = (i_y3 < i_y4) ? i_y3 : i_y4;
        bhi_y = (i_y3 < i_y4) ? i_y4 : i_y3;
        n_box = !(ahi_x < blo_x || bhi_x < alo_x || ahi_y < blo_y || bhi_y < alo_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_adv) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_boxa <= n_box;
            r_x1a  <= i_x1;
            r_y1a  <= i_y1;
            r_ax   <= DW'(i_x2) - DW'(i_x1);
            r_ay   <= DW'(i_y2) - DW'(i_y1);
            r_bx   <= DW'(i_x3) - DW'(i_x4);
            r_by   <= DW'(i_y3) - DW'(i_y4);
            r_cx   <= DW'(i_x1) - DW'(i_x3);
            r_cy   <= DW'(i_y1) - DW'(i_y3);
        end
    end

    // stage b: the six cross products
    logic                 r_vb, r_boxb;
    logic signed [W-1:0]  r_x1b, r_y1b;
    logic signed [DW-1:0] r_axb, r_ayb;
    logic signed [PW-1:0] r_p_bycx, r_p_bxcy, r_p_aybx, r_p_axby, r_p_axcy, r_p_aycx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (i_adv) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_boxb   <= r_boxa;
            r_x1b    <= r_x1a;
            r_y1b    <= r_y1a;
            r_axb    <= r_ax;
            r_ayb    <= r_ay;
            r_p_bycx <= PW'(r_by) * PW'(r_cx);
            r_p_bxcy <= PW'(r_bx) * PW'(r_cy);
            r_p_aybx <= PW'(r_ay) * PW'(r_bx);
            r_p_axby <= PW'(r_ax) * PW'(r_by);
            r_p_axcy <= PW'(r_ax) * PW'(r_cy);
            r_p_aycx <= PW'(r_ay) * PW'(r_cx);
        end
    end

    // stage c: d, e and f
    logic                 r_vc, r_boxc;
    logic signed [W-1:0]  r_x1c, r_y1c;
    logic signed [DW-1:0] r_axc, r_ayc;
    logic signed [FW-1:0] r_d, r_e, r_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (i_adv) begin
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_boxc <= r_boxb;
            r_x1c  <= r_x1b;
            r_y1c  <= r_y1b;
            r_axc  <= r_axb;
            r_ayc  <= r_ayb;
            r_d    <= FW'(r_p_bycx) - FW'(r_p_bxcy);
            r_e    <= FW'(r_p_axcy) - FW'(r_p_aycx);
            r_f    <= FW'(r_p_aybx) - FW'(r_p_axby);
        end
    end

    // stage d: span tests, status and magnitudes
    logic    d_in, e_in, f_pos;
    t_status n_status;

    always_comb begin
        f_pos = (r_f > 0);
        d_in  = f_pos ? (r_d >= 0 && r_d <= r_f) : (r_d <= 0 && r_d >= r_f);
        e_in  = f_pos ? (r_e >= 0 && r_e <= r_f) : (r_e <= 0 && r_e >= r_f);
        if (!r_boxc || !d_in || !e_in) begin
            n_status = ST_MISS;
        end else if (r_f == 0) begin
            n_status = ST_COLLINEAR;
        end else begin
            n_status = ST_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_status <= n_status;
            o_dm     <= r_d[FW-1] ? FW'(-r_d) : FW'(r_d);
            o_fm     <= r_f[FW-1] ? FW'(-r_f) : FW'(r_f);
            o_amx    <= r_axc[DW-1] ? DW'(-r_axc) : DW'(r_axc);
            o_amy    <= r_ayc[DW-1] ? DW'(-r_ayc) : DW'(r_ayc);
            o_negx   <= r_axc[DW-1];
            o_negy   <= r_ayc[DW-1];
            o_bx     <= r_x1c;
            o_by     <= r_y1c;
        end
    end

endmodule

`default_nettype wire

[rtl/si_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module si_cell #(
    parameter int unsigned W   = 16,
    parameter int unsigned BIT = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire logic                i_valid,
    input  wire si_pkg::t_status     i_status,
    input  wire logic [2*W+2:0]      i_dm,
    input  wire logic [2*W+2:0]      i_fm,
    input  wire logic [W:0]          i_amx,
    input  wire logic [W:0]          i_amy,
    input  wire logic                i_negx,
    input  wire logic                i_negy,
    input  wire logic signed [W-1:0] i_bx,
    input  wire logic signed [W-1:0] i_by,
    input  wire logic [2*W+2:0]      i_rx,
    input  wire logic [W+1:0]        i_qx,
    input  wire logic [2*W+2:0]      i_ry,
    input  wire logic [W+1:0]        i_qy,
    output logic                     o_valid,
    output si_pkg::t_status          o_status,
    output logic [2*W+2:0]           o_dm,
    output logic [2*W+2:0]           o_fm,
    output logic [W:0]               o_amx,
    output logic [W:0]               o_amy,
    output logic                     o_negx,
    output logic                     o_negy,
    output logic signed [W-1:0]      o_bx,
    output logic signed [W-1:0]      o_by,
    output logic [2*W+2:0]           o_rx,
    output logic [W+1:0]             o_qx,
    output logic [2*W+2:0]           o_ry,
    output logic [W+1:0]             o_qy
);
    import si_pkg::*;

    localparam int unsigned MW = 2 * W + 3;
    localparam int unsigned QW = W + 2;

    // one restoring step of (dm * am) / fm for a single multiplier bit
    function automatic logic [MW+QW-1:0] div_step(
        input logic [MW-1:0] r,
        input logic [QW-1:0] q,
        input logic          b,
        input logic [MW-1:0] dm,
        input logic [MW-1:0] fm
    );
        logic [MW:0]   t;
        logic [QW-1:0] nq;
        t  = {r, 1'b0};
        nq = {q[QW-2:0], 1'b0};
        if (t >= {1'b0, fm}) begin
            t  = t - {1'b0, fm};
            nq = nq + QW'(1);
        end
        if (b) begin
            t = t + {1'b0, dm};
            if (t >= {1'b0, fm}) begin
                t  = t - {1'b0, fm};
                nq = nq + QW'(1);
            end
        end
        return {t[MW-1:0], nq};
    endfunction

    logic [MW+QW-1:0] n_x, n_y;

    always_comb begin
        n_x = div_step(i_rx, i_qx, i_amx[BIT], i_dm, i_fm);
        n_y = div_step(i_ry, i_qy, i_amy[BIT], i_dm, i_fm);
    end

    // valid travels with the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_status <= i_status;
            o_dm     <= i_dm;
            o_fm     <= i_fm;
            o_amx    <= i_amx;
            o_amy    <= i_amy;
            o_negx   <= i_negx;
            o_negy   <= i_negy;
            o_bx     <= i_bx;
            o_by     <= i_by;
            o_rx     <= n_x[MW+QW-1:QW];
            o_qx     <= n_x[QW-1:0];
            o_ry     <= n_y[MW+QW-1:QW];
            o_qy     <= n_y[QW-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/segment_intersection.sv]
`timescale 1ns / 1ps
`default_nettype none

// Segment intersection engine. Accepts one segment pair per clock while ready
// is high and returns one result per pair in order: status (miss, hit or
// collinear) and the crossing point, its offset from the start of segment a
// rounded half away from zero; the point is zero unless the status is hit.
// The pipeline has four front stages for differences, box test, products and
// span tests, then a chain of COORD_BITS + 1 divider cells that each resolve
// one quotient bit of the x and y offsets, then the rounding and output
// register. The whole pipeline holds while a result waits at the output, so
// throughput is one pair per cycle whenever the sink keeps ready high.
module segment_intersection #(
    parameter int unsigned COORD_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    si_in_if.sink     i_in,
    si_out_if.source  o_out
);
    import si_pkg::*;

    localparam int unsigned W  = COORD_BITS;
    localparam int unsigned MW = 2 * W + 3;
    localparam int unsigned QW = W + 2;
    localparam int unsigned NC = W + 1;

    logic adv;
    logic r_out_valid;

    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = adv;

    // chain taps, index 0 is the front end output
    logic                c_valid  [0:NC];
    t_status             c_status [0:NC];
    logic [MW-1:0]       c_dm     [0:NC];
    logic [MW-1:0]       c_fm     [0:NC];
    logic [W:0]          c_amx    [0:NC];
    logic [W:0]          c_amy    [0:NC];
    logic                c_negx   [0:NC];
    logic                c_negy   [0:NC];
    logic signed [W-1:0] c_bx     [0:NC];
    logic signed [W-1:0] c_by     [0:NC];
    logic [MW-1:0]       c_rx     [0:NC];
    logic [QW-1:0]       c_qx     [0:NC];
    logic [MW-1:0]       c_ry     [0:NC];
    logic [QW-1:0]       c_qy     [0:NC];

    si_front #(.W(W)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (i_in.valid),
        .i_x1     (i_in.ax_start),
        .i_y1     (i_in.ay_start),
        .i_x2     (i_in.ax_end),
        .i_y2     (i_in.ay_end),
        .i_x3     (i_in.bx_start),
        .i_y3     (i_in.by_start),
        .i_x4     (i_in.bx_end),
        .i_y4     (i_in.by_end),
        .o_valid  (c_valid[0]),
        .o_status (c_status[0]),
        .o_dm     (c_dm[0]),
        .o_fm     (c_fm[0]),
        .o_amx    (c_amx[0]),
        .o_amy    (c_amy[0]),
        .o_negx   (c_negx[0]),
        .o_negy   (c_negy[0]),
        .o_bx     (c_bx[0]),
        .o_by     (c_by[0])
    );

    assign c_rx[0] = '0;
    assign c_qx[0] = '0;
    assign c_ry[0] = '0;
    assign c_qy[0] = '0;

    // divider cells, most significant multiplier bit first
    for (genvar k = 0; k < NC; k++) begin : g_cell
        si_cell #(.W(W), .BIT(W - k)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_valid  (c_valid[k]),
            .i_status (c_status[k]),
            .i_dm     (c_dm[k]),
            .i_fm     (c_fm[k]),
            .i_amx    (c_amx[k]),
            .i_amy    (c_amy[k]),
            .i_negx   (c_negx[k]),
            .i_negy   (c_negy[k]),
            .i_bx     (c_bx[k]),
            .i_by     (c_by[k]),
            .i_rx     (c_rx[k]),
            .i_qx     (c_qx[k]),
            .i_ry     (c_ry[k]),
            .i_qy     (c_qy[k]),
            .o_valid  (c_valid[k+1]),
            .o_status (c_status[k+1]),
            .o_dm     (c_dm[k+1]),
            .o_fm     (c_fm[k+1]),
            .o_amx    (c_amx[k+1]),
            .o_amy    (c_amy[k+1]),
            .o_negx   (c_negx[k+1]),
            .o_negy   (c_negy[k+1]),
            .o_bx     (c_bx[k+1]),
            .o_by     (c_by[k+1]),
            .o_rx     (c_rx[k+1]),
            .o_qx     (c_qx[k+1]),
            .o_ry     (c_ry[k+1]),
            .o_qy     (c_qy[k+1])
        );
    end

    // rounding by half the divisor, then offset from the start point
    logic [MW:0]         rnd_x, rnd_y, half_f;
    logic [QW-1:0]       qx_f, qy_f;
    logic signed [QW:0]  sum_x, sum_y;
    logic                hit;
    logic signed [W-1:0] n_cx, n_cy;

    always_comb begin
        half_f = {1'b0, 1'b0, c_fm[NC][MW-1:1]};
        rnd_x  = {1'b0, c_rx[NC]} + half_f;
        rnd_y  = {1'b0, c_ry[NC]} + half_f;
        qx_f   = c_qx[NC] + QW'(rnd_x >= {1'b0, c_fm[NC]});
        qy_f   = c_qy[NC] + QW'(rnd_y >= {1'b0, c_fm[NC]});
        sum_x  = c_negx[NC] ? (QW+1)'(c_bx[NC]) - $signed({1'b0, qx_f})
                            : (QW+1)'(c_bx[NC]) + $signed({1'b0, qx_f});
        sum_y  = c_negy[NC] ? (QW+1)'(c_by[NC]) - $signed({1'b0, qy_f})
                            : (QW+1)'(c_by[NC]) + $signed({1'b0, qy_f});
        hit    = (c_status[NC] == ST_HIT);
        n_cx   = hit ? sum_x[W-1:0] : '0;
        n_cy   = hit ? sum_y[W-1:0] : '0;
    end

    // output register
    logic [STATUS_BITS-1:0] r_status;
    logic signed [W-1:0]    r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= c_valid[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_status <= c_status[NC];
            r_cx     <= n_cx;
            r_cy     <= n_cy;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.status  = r_status;
    assign o_out.cross_x = r_cx;
    assign o_out.cross_y = r_cy;

    // checks
    a_zero_unless_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != ST_HIT |-> o_out.cross_x == 0 && o_out.cross_y == 0)
        else $error("coordinates nonzero on a non-hit result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.status == ST_MISS || o_out.status == ST_HIT
                        || o_out.status == ST_COLLINEAR)
        else $error("status code out of range");

    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input taken while the output is stalled");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(c_valid[NC]) && $stable(c_qx[NC]))
        else $error("divider chain moved during a stall");

endmodule

`default_nettype wire
